>>> rtl/rpct_pkg.sv
`timescale 1ns / 1ps
package rpct_pkg;

  localparam int unsigned PosW   = 31;
  localparam int unsigned ShiftW = 16;
  localparam int unsigned ScaleW = 24;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [ScaleW-1:0] ScaleReset = 24'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FIVE_SHIFT  = 3'd0,
    REG_THREE_SHIFT = 3'd1,
    REG_TRACK_LEN   = 3'd2,
    REG_SCALE       = 3'd3,
    REG_BASELINE    = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_LEAD,
    ST_SWEEP,
    ST_FINISH
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic insert;
    logic lead;
    logic step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_tag;
    logic no_tags;
    logic sweep_done;
  } dp_status_t;

endpackage

>>> rtl/rpct_ctrl.sv
`timescale 1ns / 1ps
module rpct_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  rpct_pkg::dp_status_t  status_i,
  output rpct_pkg::dp_cmd_t     cmd_o,
  output logic                  busy_o
);
  import rpct_pkg::*;

  ctrl_state_e state_q, state_d;

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequence load, lead run, sweep and final result
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd_o.insert = 1'b1;
        if (!status_i.last_tag) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_LEAD;
        end
      end
      ST_LEAD: begin
        if (status_i.no_tags) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.lead = 1'b1;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (status_i.sweep_done) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/rpct_datapath.sv
`timescale 1ns / 1ps
module rpct_datapath #(
  parameter int unsigned MAX_TAGS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rpct_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rpct_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic [rpct_pkg::PosW-1:0]         tag_position_i,
  input  logic                              minus_strand_i,
  input  logic                              last_tag_i,
  input  rpct_pkg::dp_cmd_t                 cmd_i,
  output rpct_pkg::dp_status_t              status_o,
  output logic                              valid_o,
  output logic [rpct_pkg::PosW-1:0]         boundary_position_o,
  output logic signed [rpct_pkg::ValW-1:0]  coverage_value_o,
  output logic                              last_of_run_o,
  output logic                              empty_track_o,
  output logic                              tags_dropped_o
);
  import rpct_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_TAGS + 1);
  localparam int unsigned IdxW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int unsigned ExtW = PosW + 2;

  // configuration registers
  logic signed [ShiftW-1:0] five_q, three_q;
  logic [PosW-1:0]          len_q;
  logic [ScaleW-1:0]        scale_q;
  logic signed [ValW-1:0]   base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      five_q  <= '0;
      three_q <= '0;
      len_q   <= '0;
      scale_q <= ScaleReset;
      base_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIVE_SHIFT:  five_q  <= cfg_wdata_i[ShiftW-1:0];
        REG_THREE_SHIFT: three_q <= cfg_wdata_i[ShiftW-1:0];
        REG_TRACK_LEN:   len_q   <= cfg_wdata_i[PosW-1:0];
        REG_SCALE:       scale_q <= cfg_wdata_i[ScaleW-1:0];
        REG_BASELINE:    base_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // captured transaction
  logic [PosW-1:0] tag_q;
  logic            minus_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tag_q   <= tag_position_i;
      minus_q <= minus_strand_i;
      last_q  <= last_tag_i;
    end
  end

  // fragment ends, clamped to the track
  logic signed [ExtW-1:0] tag_x, s_raw, e_raw, len_x;
  logic signed [ExtW-1:0] sh_s, sh_e;
  logic [PosW-1:0]        s_clamp, e_clamp;

  always_comb begin
    tag_x = $signed({2'b00, tag_q});
    len_x = $signed({2'b00, len_q});
    sh_s  = ExtW'(minus_q ? three_q : five_q);
    sh_e  = ExtW'(minus_q ? five_q : three_q);
    s_raw = tag_x - sh_s;
    e_raw = tag_x + sh_e;
    if (s_raw < 0) s_clamp = '0;
    else if (s_raw > len_x) s_clamp = len_q;
    else s_clamp = s_raw[PosW-1:0];
    if (e_raw < 0) e_clamp = '0;
    else if (e_raw > len_x) e_clamp = len_q;
    else e_clamp = e_raw[PosW-1:0];
  end

  // sorted stores with parallel insertion
  logic [PosW-1:0] st_q [MAX_TAGS];
  logic [PosW-1:0] en_q [MAX_TAGS];
  logic [CntW-1:0] n_q;
  logic            ovf_q;
  logic            room;

  assign room = (n_q < CntW'(MAX_TAGS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert && room) begin
      for (int i = 0; i < MAX_TAGS; i++) begin
        if ((CntW'(i) < n_q) && (st_q[i] <= s_clamp)) st_q[i] <= st_q[i];
        else if ((i > 0) && (CntW'(i) <= n_q) && (st_q[(i > 0) ? i - 1 : 0] > s_clamp))
          st_q[i] <= st_q[(i > 0) ? i - 1 : 0];
        else if (CntW'(i) <= n_q) st_q[i] <= s_clamp;

        if ((CntW'(i) < n_q) && (en_q[i] <= e_clamp)) en_q[i] <= en_q[i];
        else if ((i > 0) && (CntW'(i) <= n_q) && (en_q[(i > 0) ? i - 1 : 0] > e_clamp))
          en_q[i] <= en_q[(i > 0) ? i - 1 : 0];
        else if (CntW'(i) <= n_q) en_q[i] <= e_clamp;
      end
    end
  end

  // fill count and drop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.finish) begin
      n_q   <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.insert) begin
      if (room) n_q <= n_q + CntW'(1);
      else ovf_q <= 1'b1;
    end
  end

  // sweep cursors, running value and last boundary
  logic [CntW-1:0]        is_q, ie_q;
  logic signed [ValW-1:0] acc_q;
  logic [PosW-1:0]        prev_q;
  logic [PosW-1:0]        s_rd, e_rd;
  logic signed [ValW-1:0] scale_x, lvl;
  logic                   s_ok, e_ok, take_s, take_both;

  assign s_rd    = st_q[is_q[IdxW-1:0]];
  assign e_rd    = en_q[ie_q[IdxW-1:0]];
  assign s_ok    = (is_q < n_q);
  assign e_ok    = (ie_q < n_q);
  assign take_s  = s_ok && (s_rd < e_rd);
  assign take_both = s_ok && (s_rd == e_rd);
  assign scale_x = $signed({{(ValW-ScaleW){1'b0}}, scale_q});
  assign lvl     = (acc_q < base_q) ? base_q : acc_q;

  assign status_o.last_tag   = last_q;
  assign status_o.no_tags    = (n_q == '0);
  assign status_o.sweep_done = !e_ok;

  // candidate emission of this cycle
  logic                   emit;
  logic [PosW-1:0]        emit_pos;
  logic signed [ValW-1:0] emit_val;

  always_comb begin
    emit     = 1'b0;
    emit_pos = e_rd;
    emit_val = lvl;
    if (cmd_i.lead) begin
      // leading run ends at the smaller of the two first entries
      emit_pos = (st_q[0] < en_q[0]) ? st_q[0] : en_q[0];
      emit_val = (base_q > 0) ? base_q : '0;
      emit     = (emit_pos != '0);
    end else if (cmd_i.step) begin
      if (take_s) begin
        emit_pos = s_rd;
        emit     = (s_rd != prev_q);
      end else if (!take_both) begin
        emit_pos = e_rd;
        emit     = (e_rd != prev_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lead) begin
      is_q   <= '0;
      ie_q   <= '0;
      acc_q  <= '0;
      prev_q <= emit_pos;
    end else if (cmd_i.step) begin
      if (take_s) begin
        is_q  <= is_q + CntW'(1);
        acc_q <= acc_q + scale_x;
      end else if (take_both) begin
        is_q <= is_q + CntW'(1);
        ie_q <= ie_q + CntW'(1);
      end else begin
        ie_q  <= ie_q + CntW'(1);
        acc_q <= acc_q - scale_x;
      end
      if (emit) prev_q <= emit_pos;
    end
  end

  // pending result: released when the next one arrives or at the end
  logic                   pend_q;
  logic [PosW-1:0]        ppos_q;
  logic signed [ValW-1:0] pval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (cmd_i.finish) begin
      pend_q <= 1'b0;
    end else if (emit) begin
      pend_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ppos_q <= emit_pos;
      pval_q <= emit_val;
    end
  end

  // output register
  logic                   vld_q, lst_q, emp_q, drp_q;
  logic [PosW-1:0]        opos_q;
  logic signed [ValW-1:0] oval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cmd_i.finish || (emit && pend_q);
    end
  end

  always_ff @(posedge clk_i) begin
    opos_q <= ppos_q;
    oval_q <= pval_q;
    lst_q  <= cmd_i.finish;
    emp_q  <= cmd_i.finish && !pend_q;
    drp_q  <= ovf_q;
    if (cmd_i.finish && !pend_q) begin
      opos_q <= '0;
      oval_q <= '0;
    end
  end

  assign valid_o             = vld_q;
  assign boundary_position_o = opos_q;
  assign coverage_value_o    = oval_q;
  assign last_of_run_o       = lst_q;
  assign empty_track_o       = emp_q;
  assign tags_dropped_o      = drp_q;

endmodule

>>> rtl/read_pileup_coverage_track.sv
`timescale 1ns / 1ps
// Channel  | Ports                                        | Handshake
// tag in   | tag_position_i, minus_strand_i, last_tag_i   | start_i & !busy_o
// config   | cfg_idx_i, cfg_wdata_i                       | cfg_we_i
// result   | boundary_position_o, coverage_value_o, ...   | valid_o strobe
//
// A tag is captured, then inserted into both sorted stores in one parallel
// step. A last tag adds a lead step, a sweep of at most 2*MAX_TAGS store
// steps plus a step that sees the end, and a final step; each result is held
// one emission, and the last shows in the cycle after the final step.
// Reset clears the state, fill count, drop flag and configuration registers; stores are not cleared.
// The receiver cannot stall: each result shows on valid_o for one cycle.
module read_pileup_coverage_track #(
  parameter int unsigned MAX_TAGS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [rpct_pkg::PosW-1:0]         tag_position_i,
  input  logic                              minus_strand_i,
  input  logic                              last_tag_i,
  input  logic                              cfg_we_i,
  input  logic [rpct_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rpct_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output logic                              valid_o,
  output logic [rpct_pkg::PosW-1:0]         boundary_position_o,
  output logic signed [rpct_pkg::ValW-1:0]  coverage_value_o,
  output logic                              last_of_run_o,
  output logic                              empty_track_o,
  output logic                              tags_dropped_o
);
  import rpct_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rpct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  rpct_datapath #(
    .MAX_TAGS (MAX_TAGS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .tag_position_i      (tag_position_i),
    .minus_strand_i      (minus_strand_i),
    .last_tag_i          (last_tag_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .valid_o             (valid_o),
    .boundary_position_o (boundary_position_o),
    .coverage_value_o    (coverage_value_o),
    .last_of_run_o       (last_of_run_o),
    .empty_track_o       (empty_track_o),
    .tags_dropped_o      (tags_dropped_o)
  );

endmodule

>>> rtl/rpct_checker.sv
`timescale 1ns / 1ps
module rpct_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              busy_o,
  input logic                              valid_o,
  input logic [rpct_pkg::PosW-1:0]         boundary_position_o,
  input logic signed [rpct_pkg::ValW-1:0]  coverage_value_o,
  input logic                              last_of_run_o,
  input logic                              empty_track_o
);
  import rpct_pkg::*;

  // results before the final one only appear while a track is being swept
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_of_run_o) |-> busy_o) else $error("result outside a sweep");

  // an empty track is a single, final result
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && empty_track_o) |-> last_of_run_o) else $error("empty not final");

  // the empty result carries zero position and value
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && empty_track_o) |-> (boundary_position_o == '0 && coverage_value_o == '0))
    else $error("empty result not zero");

  // the final result shows once the block is idle again, with no result after it
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_of_run_o) |-> (!busy_o ##1 !valid_o)) else $error("sweep ran past end");

endmodule

bind read_pileup_coverage_track rpct_checker u_rpct_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .busy_o              (busy_o),
  .valid_o             (valid_o),
  .boundary_position_o (boundary_position_o),
  .coverage_value_o    (coverage_value_o),
  .last_of_run_o       (last_of_run_o),
  .empty_track_o       (empty_track_o)
);
